/* hdl/alarm_slot_table_assert.svh */
// ----------------------------------------------------------------------------
// Alarm slot table assertion macros
// Shorthand for clocked checks that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ALARM_SLOT_TABLE_ASSERT_SVH
`define ALARM_SLOT_TABLE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define AST_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define AST_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ast_pkg.sv */
// ----------------------------------------------------------------------------
// Alarm slot table package
// Beat types, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package ast_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 32;

   // Operation codes of the request beat
   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_ARM     = 3'd2;
   localparam logic [2:0] OP_CANCEL  = 3'd3;
   localparam logic [2:0] OP_STATUS  = 3'd4;
   localparam logic [2:0] OP_TICK    = 3'd5;

   // Status codes of the response beat
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOT_USED = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  slot;
      logic [31:0] delay_seconds;
      logic        notify;
   } req_type;

   typedef struct packed {
      logic [3:0]  slot_index;
      logic        fired;
      logic [31:0] remaining;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_STATUS,
      S_TICK,
      S_TICK_LAST,
      S_TICK_END
   } state_type;

endpackage

/* hdl/ast_ram.sv */
// ----------------------------------------------------------------------------
// Alarm slot table RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ast_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ast_time.sv */
// ----------------------------------------------------------------------------
// Alarm slot table time arithmetic
// Saturating clock advance, saturating expiry sum, expiry compare and
// seconds-left computation.
// ----------------------------------------------------------------------------
module ast_time #(
   parameter int TIME_BITS = 32
) (
   input  logic [TIME_BITS-1:0] now,
   input  logic [31:0]          delay,
   input  logic [TIME_BITS-1:0] expiry,
   output logic [TIME_BITS-1:0] now_next,
   output logic [TIME_BITS-1:0] arm_expiry,
   output logic                 expired,
   output logic [31:0]          remaining
);

   localparam int SUM_W  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
   localparam int DIFF_W = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [SUM_W-1:0]     sum;
   logic [TIME_BITS-1:0] diff;
   logic [DIFF_W-1:0]    diff_wide;

   // Advance the clock, stopping at the top value
   assign now_next = (now == TIME_MAX) ? now : now + TIME_BITS'(1);

   // Clamp now plus delay to the top value
   assign sum        = SUM_W'(now) + SUM_W'(delay);
   assign arm_expiry = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];

   // Expiry at or before now
   assign expired = (expiry <= now);

   // Seconds left, clamped to the result field
   assign diff      = expiry - now;
   assign diff_wide = DIFF_W'(diff);
   assign remaining = (diff_wide > DIFF_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                          : diff_wide[31:0];

endmodule

/* hdl/alarm_slot_table.sv */
// ----------------------------------------------------------------------------
// Alarm slot table
// Slot allocator with per-slot alarms driven by a saturating seconds counter.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Results come
// out as single-cycle rsp_strobe pulses that cannot be held off; the last
// result of a request has last set. Release, arm, cancel and unknown codes
// answer in the cycle after the request and leave busy low, so a new
// request may follow at once. Status of a used slot reads the expiry
// memory and answers after its registered read and the result register.
// Allocate steps through the used bits one slot per cycle. A tick sweeps
// every slot through the single read port of the expiry and notify
// memories, one slot per cycle, with the compare in the cycle after the
// read: busy stays high through S_TICK, S_TICK_LAST and S_TICK_END. Each
// notifying expiry gives one fired result, in ascending slot order; a tick
// with none gives a single all-zero result with last set. Used and armed
// bits sit in flip-flops cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module alarm_slot_table #(
   parameter int SLOTS     = ast_pkg::SLOTS_DEF,
   parameter int TIME_BITS = ast_pkg::TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ast_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ast_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   ast_pkg::state_type   state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [SLOTS-1:0]     used_ff, used_in;
   logic [SLOTS-1:0]     armed_ff, armed_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]     slot_idx_ff, slot_idx_in;
   logic                 notify_ff, notify_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   ast_pkg::rsp_type     rsp_item_ff, rsp_item_in;

   logic                 accept;
   logic [IDX_W-1:0]     req_idx;
   logic                 slot_ok;
   logic                 scan_last;
   logic [IDX_W-1:0]     rd_addr;
   logic                 exp_wr_en;
   logic                 ntf_wr_en;
   logic [TIME_BITS-1:0] exp_rd_data;
   logic                 ntf_rd_data;
   logic [TIME_BITS-1:0] now_next;
   logic [TIME_BITS-1:0] arm_expiry;
   logic                 expired;
   logic [31:0]          remaining;

   assign busy      = (state_ff != ast_pkg::S_IDLE);
   assign accept    = start && !busy;
   assign req_idx   = IDX_W'(req_item.slot);
   assign slot_ok   = (32'(req_item.slot) < SLOTS) && used_ff[req_idx];
   assign scan_last = (scan_idx_ff == IDX_W'(SLOTS - 1));

   // Read at the request slot while idle, at the sweep pointer otherwise
   assign rd_addr = (state_ff == ast_pkg::S_IDLE) ? req_idx : scan_idx_ff;

   // Expiry memory: written by arm, read by status and tick
   ast_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (SLOTS)
   ) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (req_idx),
      .wr_data (arm_expiry),
      .rd_addr (rd_addr),
      .rd_data (exp_rd_data)
   );

   // Notify memory: written by allocate, read by tick
   ast_ram #(
      .WIDTH (1),
      .DEPTH (SLOTS)
   ) u_ntf_ram (
      .clock   (clock),
      .wr_en   (ntf_wr_en),
      .wr_addr (scan_idx_ff),
      .wr_data (notify_ff),
      .rd_addr (rd_addr),
      .rd_data (ntf_rd_data)
   );

   ast_time #(
      .TIME_BITS (TIME_BITS)
   ) u_time (
      .now        (now_ff),
      .delay      (req_item.delay_seconds),
      .expiry     (exp_rd_data),
      .now_next   (now_next),
      .arm_expiry (arm_expiry),
      .expired    (expired),
      .remaining  (remaining)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ast_pkg::S_IDLE: begin
            if (start) begin
               case (req_item.op)
                  ast_pkg::OP_ALLOC:  state_in = ast_pkg::S_ALLOC;
                  ast_pkg::OP_STATUS: state_in = slot_ok ? ast_pkg::S_STATUS
                                                         : ast_pkg::S_IDLE;
                  ast_pkg::OP_TICK:   state_in = ast_pkg::S_TICK;
                  default:            state_in = ast_pkg::S_IDLE;
               endcase
            end
         end
         ast_pkg::S_ALLOC: begin
            if (!used_ff[scan_idx_ff] || scan_last) begin
               state_in = ast_pkg::S_IDLE;
            end
         end
         ast_pkg::S_STATUS:    state_in = ast_pkg::S_IDLE;
         ast_pkg::S_TICK: begin
            if (scan_last) begin
               state_in = ast_pkg::S_TICK_LAST;
            end
         end
         ast_pkg::S_TICK_LAST: state_in = ast_pkg::S_TICK_END;
         ast_pkg::S_TICK_END:  state_in = ast_pkg::S_IDLE;
         default:              state_in = ast_pkg::S_IDLE;
      endcase
   end

   // Datapath and result beats
   always_comb begin
      now_in        = now_ff;
      used_in       = used_ff;
      armed_in      = armed_ff;
      scan_idx_in   = scan_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      slot_idx_in   = slot_idx_ff;
      notify_in     = notify_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '0;
      exp_wr_en     = 1'b0;
      ntf_wr_en     = 1'b0;

      case (state_ff)
         ast_pkg::S_IDLE: begin
            if (start) begin
               slot_idx_in   = req_idx;
               notify_in     = req_item.notify;
               scan_idx_in   = '0;
               pend_valid_in = 1'b0;
               case (req_item.op)
                  ast_pkg::OP_ALLOC: begin
                     // sweep starts next cycle
                  end
                  ast_pkg::OP_RELEASE, ast_pkg::OP_ARM, ast_pkg::OP_CANCEL: begin
                     rsp_strobe_in          = 1'b1;
                     rsp_item_in.slot_index = req_item.slot;
                     rsp_item_in.last       = 1'b1;
                     if (!slot_ok) begin
                        rsp_item_in.status = ast_pkg::STAT_NOT_USED;
                     end else if (req_item.op == ast_pkg::OP_RELEASE) begin
                        used_in[req_idx]  = 1'b0;
                        armed_in[req_idx] = 1'b0;
                     end else if (req_item.op == ast_pkg::OP_ARM) begin
                        exp_wr_en         = 1'b1;
                        armed_in[req_idx] = 1'b1;
                     end else begin
                        armed_in[req_idx] = 1'b0;
                     end
                  end
                  ast_pkg::OP_STATUS: begin
                     // a used slot answers once the expiry read returns
                     if (!slot_ok) begin
                        rsp_strobe_in          = 1'b1;
                        rsp_item_in.slot_index = req_item.slot;
                        rsp_item_in.status     = ast_pkg::STAT_NOT_USED;
                        rsp_item_in.last       = 1'b1;
                     end
                  end
                  ast_pkg::OP_TICK: begin
                     now_in = now_next;
                  end
                  default: begin
                     rsp_strobe_in    = 1'b1;
                     rsp_item_in.last = 1'b1;
                  end
               endcase
            end
         end
         ast_pkg::S_ALLOC: begin
            if (!used_ff[scan_idx_ff]) begin
               // claim the first free slot
               used_in[scan_idx_ff]   = 1'b1;
               armed_in[scan_idx_ff]  = 1'b0;
               ntf_wr_en              = 1'b1;
               rsp_strobe_in          = 1'b1;
               rsp_item_in.slot_index = 4'(scan_idx_ff);
               rsp_item_in.last       = 1'b1;
            end else if (scan_last) begin
               rsp_strobe_in      = 1'b1;
               rsp_item_in.status = ast_pkg::STAT_FULL;
               rsp_item_in.last   = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ast_pkg::S_STATUS: begin
            rsp_strobe_in          = 1'b1;
            rsp_item_in.slot_index = 4'(slot_idx_ff);
            rsp_item_in.last       = 1'b1;
            if (armed_ff[slot_idx_ff] && !expired) begin
               rsp_item_in.remaining = remaining;
            end
         end
         ast_pkg::S_TICK: begin
            // issue the read for this slot, compare it next cycle
            chk_valid_in = 1'b1;
            chk_idx_in   = scan_idx_ff;
            if (!scan_last) begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ast_pkg::S_TICK_LAST: begin
            // compare stage finishes the final slot
         end
         ast_pkg::S_TICK_END: begin
            rsp_strobe_in    = 1'b1;
            rsp_item_in.last = 1'b1;
            if (pend_valid_ff) begin
               rsp_item_in.slot_index = 4'(pend_idx_ff);
               rsp_item_in.fired      = 1'b1;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase

      // Compare stage of the sweep: disarm and hold back one fired beat
      // so the final one can carry last
      if (chk_valid_ff && used_ff[chk_idx_ff] && armed_ff[chk_idx_ff] && expired) begin
         armed_in[chk_idx_ff] = 1'b0;
         if (ntf_rd_data) begin
            if (pend_valid_ff) begin
               rsp_strobe_in          = 1'b1;
               rsp_item_in.slot_index = 4'(pend_idx_ff);
               rsp_item_in.fired      = 1'b1;
            end
            pend_valid_in = 1'b1;
            pend_idx_in   = chk_idx_ff;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ast_pkg::S_IDLE;
         now_ff        <= '0;
         used_ff       <= '0;
         armed_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         used_ff       <= used_in;
         armed_ff      <= armed_in;
         chk_valid_ff  <= chk_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      pend_idx_ff <= pend_idx_in;
      slot_idx_ff <= slot_idx_in;
      notify_ff   <= notify_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`include "alarm_slot_table_assert.svh"

   `AST_CHECK(a_armed_is_used, 1'b1, ((armed_ff & ~used_ff) == '0), "armed slot not in use")
   `AST_CHECK(a_full_is_full, (rsp_strobe && rsp_item.status == ast_pkg::STAT_FULL), (&used_ff), "full reported with a free slot")
   `AST_CHECK_NEXT(a_quick_answer, (accept && (req_item.op == ast_pkg::OP_RELEASE || req_item.op == ast_pkg::OP_ARM || req_item.op == ast_pkg::OP_CANCEL)), (rsp_strobe && rsp_item.last), "missing single-beat answer")
   `AST_CHECK_NEXT(a_tick_closes, (state_ff == ast_pkg::S_TICK_END), (rsp_strobe && rsp_item.last && !busy), "tick sweep did not close")

endmodule
